>>> design/rcpwc_pkg.sv
// ----------------------------------------------------------------------------
// rcpwc_pkg
// Shared types and constants for the RC pulse-width capture unit.
// ----------------------------------------------------------------------------
package rcpwc_pkg;

  // Channel slots carried by the pins and the result
  localparam int unsigned CH_SLOTS  = 4;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0] DEFAULT_MIN_WIDTH = 16'd1000;
  localparam logic [WIDTH_W-1:0] DEFAULT_MAX_WIDTH = 16'd2000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_WIDTH = 1'b0,
    REG_MAX_WIDTH = 1'b1
  } cfg_reg_e;

  // Input transaction
  typedef struct packed {
    logic [CH_SLOTS-1:0] pin_levels;
    logic [STAMP_W-1:0]  time_us;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [WIDTH_W-1:0]  width_ch0;
    logic [WIDTH_W-1:0]  width_ch1;
    logic [WIDTH_W-1:0]  width_ch2;
    logic [WIDTH_W-1:0]  width_ch3;
    logic [CH_SLOTS-1:0] updated_mask;
  } out_t;

  // Acceptance window handed to the channels
  typedef struct packed {
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] max_width;
  } window_t;

endpackage

>>> design/rcpwc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcpwc_cfg_regs
// Minimum and maximum pulse-width registers with their write port.
// ----------------------------------------------------------------------------
module rcpwc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcpwc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcpwc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output rcpwc_pkg::window_t                   window_o
);
  import rcpwc_pkg::*;

  logic [WIDTH_W-1:0] min_width_q, min_width_d;
  logic [WIDTH_W-1:0] max_width_q, max_width_d;

  // Decode the write
  always_comb begin
    min_width_d = min_width_q;
    max_width_d = max_width_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_WIDTH: min_width_d = cfg_wdata_i[WIDTH_W-1:0];
        REG_MAX_WIDTH: max_width_d = cfg_wdata_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q <= DEFAULT_MIN_WIDTH;
      max_width_q <= DEFAULT_MAX_WIDTH;
    end else begin
      min_width_q <= min_width_d;
      max_width_q <= max_width_d;
    end
  end

  assign window_o.min_width = min_width_q;
  assign window_o.max_width = max_width_q;

endmodule

>>> design/rcpwc_channel.sv
// ----------------------------------------------------------------------------
// rcpwc_channel
// Edge detection, rise timestamp and filtered width for one channel.
// ----------------------------------------------------------------------------
module rcpwc_channel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               level_i,
  input  logic [rcpwc_pkg::STAMP_W-1:0]      now_i,
  input  rcpwc_pkg::window_t                 window_i,
  output logic [rcpwc_pkg::WIDTH_W-1:0]      width_o,
  output logic                               update_o
);
  import rcpwc_pkg::*;

  logic               last_level_q, last_level_d;
  logic [STAMP_W-1:0] rise_stamp_q, rise_stamp_d;
  logic [WIDTH_W-1:0] held_width_q, held_width_d;
  logic [STAMP_W-1:0] pulse_w;
  logic               in_window;
  logic               rise;
  logic               fall;

  // Measure the pulse modulo 2^32 and check the window
  assign rise    = level_i && !last_level_q;
  assign fall    = !level_i && last_level_q;
  assign pulse_w = now_i - rise_stamp_q;
  assign in_window = (pulse_w >= {{(STAMP_W-WIDTH_W){1'b0}}, window_i.min_width}) &&
                     (pulse_w <= {{(STAMP_W-WIDTH_W){1'b0}}, window_i.max_width});
  assign update_o = fall && in_window;

  // Advance the channel state
  always_comb begin
    last_level_d = last_level_q;
    rise_stamp_d = rise_stamp_q;
    held_width_d = held_width_q;
    if (rise) begin
      last_level_d = 1'b1;
      rise_stamp_d = now_i;
    end else if (fall) begin
      last_level_d = 1'b0;
      if (in_window) begin
        // saturate a width above the field range
        held_width_d = (pulse_w[STAMP_W-1:WIDTH_W] != '0) ? '1 : pulse_w[WIDTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      rise_stamp_q <= '0;
      held_width_q <= '0;
    end else if (en_i) begin
      last_level_q <= last_level_d;
      rise_stamp_q <= rise_stamp_d;
      held_width_q <= held_width_d;
    end
  end

  // Width after this sample
  assign width_o = held_width_d;

endmodule

>>> design/rc_pulse_width_capture_unit.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_unit
// Captures high-pulse widths on the RC receiver channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one pin sample with its
//   microsecond timestamp per transaction. Output channel (out_valid_o/
//   out_ready_i/out_data_o): one result per input transaction, holding the
//   held width of each channel and the mask of channels updated by it.
//   Configuration: cfg_we_i writes cfg_wdata_i to the register selected by
//   cfg_idx_i (0 = min width, 1 = max width); write only while idle.
//   Result path: an accepted input is held in the input register, and the
//   result register loads it once that register is free or being drained.
//   Throughput: one transaction per cycle unless the result stalls; the edge, subtract
//   and window compare of every channel sit between the input and result registers.
//   Reset: clears the channel state and both stages; the window returns to
//   1000..2000 us. No clearing pass is needed.
//   Stall: while the result waits, the input register still takes one more
//   transaction; after that in_ready_o drops until out_ready_i returns.
//   Channels at or above NUM_CHANNELS report zero width and a zero mask bit.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture_unit #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rcpwc_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rcpwc_pkg::out_t                   out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rcpwc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rcpwc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import rcpwc_pkg::*;

  localparam int unsigned ActiveCh = (NUM_CHANNELS > CH_SLOTS) ? CH_SLOTS : NUM_CHANNELS;

  window_t             window;
  logic                in_valid_q;
  in_t                 in_q;
  logic                out_valid_q;
  out_t                out_q, out_d;
  logic                advance;
  logic [WIDTH_W-1:0]  width [CH_SLOTS];
  logic [CH_SLOTS-1:0] update;

  rcpwc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .window_o    (window)
  );

  // Move the input register into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Per-channel capture; unused slots read as zero
  for (genvar i = 0; i < CH_SLOTS; i++) begin : g_ch
    if (i < ActiveCh) begin : g_on
      rcpwc_channel u_ch (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (advance),
        .level_i  (in_q.pin_levels[i]),
        .now_i    (in_q.time_us),
        .window_i (window),
        .width_o  (width[i]),
        .update_o (update[i])
      );
    end else begin : g_off
      assign width[i]  = '0;
      assign update[i] = 1'b0;
    end
  end

  // Assemble the result
  always_comb begin
    out_d.width_ch0    = width[0];
    out_d.width_ch1    = width[1];
    out_d.width_ch2    = width[2];
    out_d.width_ch3    = width[3];
    out_d.updated_mask = update;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/rcpwc_checker.sv
// ----------------------------------------------------------------------------
// rcpwc_checker
// Port-level checks for the RC pulse-width capture unit.
// ----------------------------------------------------------------------------
module rcpwc_checker #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  rcpwc_pkg::out_t                   out_data_o
);
  import rcpwc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Never stall the input while the result stage is free
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result stage");

  // Drop ready only behind a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // Report nothing for channels that are not built
  a_unused_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((NUM_CHANNELS > 1) || (out_data_o.width_ch1 == '0 && !out_data_o.updated_mask[1])) &&
      ((NUM_CHANNELS > 2) || (out_data_o.width_ch2 == '0 && !out_data_o.updated_mask[2])) &&
      ((NUM_CHANNELS > 3) || (out_data_o.width_ch3 == '0 && !out_data_o.updated_mask[3])))
    else $error("unused channel reports data");

endmodule

bind rc_pulse_width_capture_unit rcpwc_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_rcpwc_checker (.*);

>>> dv/tb_rc_pulse_width_capture_unit.sv
// ----------------------------------------------------------------------------
// tb_rc_pulse_width_capture_unit
// Self-checking bench for the four-channel RC pulse-width capture unit.
// A queue-fed driver offers pin samples with timestamps. A behavioral model
// of the edge capture and the width window predicts every result. A monitor
// compares the results field by field. The run steps through several
// acceptance windows: reset default, widest, inverted, single value and
// random. The stimulus is mostly realistic pulse trains with noise mixed in.
// ----------------------------------------------------------------------------
module tb_rc_pulse_width_capture_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpwc_pkg::*;

  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned ACTIVE_CH = (NUM_CH > CH_SLOTS) ? CH_SLOTS : NUM_CH;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 150;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Block inputs, known from time zero
  logic                  in_valid_i  = 1'b0;
  in_t                   in_data_i   = '0;
  logic                  out_ready_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  out_t                  out_data_o;

  rc_pulse_width_capture_unit #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Model state: pin levels, rise stamps, held widths and the window
  logic               chan_high  [CH_SLOTS];
  logic [STAMP_W-1:0] chan_rise  [CH_SLOTS];
  logic [WIDTH_W-1:0] chan_width [CH_SLOTS];
  logic [WIDTH_W-1:0] win_min = DEFAULT_MIN_WIDTH;
  logic [WIDTH_W-1:0] win_max = DEFAULT_MAX_WIDTH;

  in_t  sample_q[$];
  out_t expected_widths_q[$];

  int unsigned err_cnt      = 0;
  int unsigned sample_cnt   = 0;
  int unsigned result_cnt   = 0;
  int unsigned capture_cnt  = 0;
  int unsigned window_cnt   = 1;
  int unsigned cycle_cnt    = 0;
  bit          quiet        = 1'b0;

  // Pulse-train generator state
  logic [STAMP_W-1:0] gen_now;
  logic               gen_high   [CH_SLOTS];
  logic [STAMP_W-1:0] gen_toggle [CH_SLOTS];

  // Advance the capture model by one pin sample and return its result
  function automatic out_t predict_widths(in_t smp);
    out_t                r;
    logic [STAMP_W-1:0]  w;
    logic [CH_SLOTS-1:0] mask;
    mask = '0;
    for (int i = 0; i < ACTIVE_CH; i++) begin
      if (smp.pin_levels[i]) begin
        if (!chan_high[i]) begin
          chan_high[i] = 1'b1;
          chan_rise[i] = smp.time_us;
        end
      end else if (chan_high[i]) begin
        w = smp.time_us - chan_rise[i];
        chan_high[i] = 1'b0;
        if (w >= {16'd0, win_min} && w <= {16'd0, win_max}) begin
          chan_width[i] = (w > 32'h0000_FFFF) ? 16'hFFFF : w[WIDTH_W-1:0];
          mask[i] = 1'b1;
        end
      end
    end
    r.width_ch0    = (ACTIVE_CH > 0) ? chan_width[0] : '0;
    r.width_ch1    = (ACTIVE_CH > 1) ? chan_width[1] : '0;
    r.width_ch2    = (ACTIVE_CH > 2) ? chan_width[2] : '0;
    r.width_ch3    = (ACTIVE_CH > 3) ? chan_width[3] : '0;
    r.updated_mask = mask;
    return r;
  endfunction

  function automatic void check_field(string name, logic [WIDTH_W-1:0] exp_v,
                                      logic [WIDTH_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // Driver: predict on acceptance, then offer the next sample or idle
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned in_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_widths_q.push_back(predict_widths(in_data_i));
        sample_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(0, 7);
            in_valid_i <= 1'b0;
          end else begin
            in_data_i  <= sample_q.pop_front();
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result, then decide the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_left;
    bit          long_hold_done;
    out_t        exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left     = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (expected_widths_q.size() == 0) begin
          $error("unexpected result transaction: %h", out_data_o);
          err_cnt++;
        end else begin
          exp_r = expected_widths_q.pop_front();
          capture_cnt += $countones(exp_r.updated_mask);
          check_field("width_ch0", exp_r.width_ch0, out_data_o.width_ch0);
          check_field("width_ch1", exp_r.width_ch1, out_data_o.width_ch1);
          check_field("width_ch2", exp_r.width_ch2, out_data_o.width_ch2);
          check_field("width_ch3", exp_r.width_ch3, out_data_o.width_ch3);
          check_field("updated_mask", {12'd0, exp_r.updated_mask},
                      {12'd0, out_data_o.updated_mask});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && result_cnt >= 200) begin
        // hold off long enough to back up the pipeline into the input
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[rc_pulse_width_capture_unit] ERROR");
      $finish;
    end
  end

  task automatic push_sample(logic [CH_SLOTS-1:0] pins, logic [STAMP_W-1:0] stamp);
    in_t s;
    s.pin_levels = pins;
    s.time_us    = stamp;
    sample_q.push_back(s);
  endtask

  // Wait until every sample is accepted and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || expected_widths_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window_reg(cfg_reg_e idx, logic [WIDTH_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_MIN_WIDTH) win_min = val;
    else win_max = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // High-pulse length: mostly around the window, sometimes anything
  function automatic int unsigned pick_high_len();
    int unsigned lo;
    int unsigned hi;
    lo = (win_min < win_max) ? win_min : win_max;
    hi = (win_min < win_max) ? win_max : win_min;
    if ($urandom_range(0, 9) < 7)
      return $urandom_range((lo > 64) ? lo - 64 : 0, hi + 64);
    return $urandom_range(0, 70000);
  endfunction

  // One random sample: pulse trains, jittered noise, or anything at all
  task automatic gen_random_sample();
    int unsigned         sel;
    logic [CH_SLOTS-1:0] pins;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      if ($urandom_range(0, 49) == 0) gen_now += $urandom_range(1000, 100000);
      else gen_now += $urandom_range(1, 150);
      for (int i = 0; i < CH_SLOTS; i++) begin
        if ($signed(gen_now - gen_toggle[i]) >= 0) begin
          gen_high[i] = !gen_high[i];
          gen_toggle[i] = gen_now + (gen_high[i] ? pick_high_len()
                                                  : $urandom_range(200, 3000));
        end
        pins[i] = gen_high[i];
      end
      push_sample(pins, gen_now);
    end else if (sel < 95) begin
      gen_now += $urandom_range(0, 2500);
      push_sample(4'($urandom), gen_now);
    end else begin
      gen_now = $urandom;
      push_sample(4'($urandom), gen_now);
    end
  endtask

  task automatic run_random(int unsigned count);
    gen_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    for (int i = 0; i < CH_SLOTS; i++) begin
      gen_high[i]   = 1'b0;
      gen_toggle[i] = gen_now + $urandom_range(0, 400);
    end
    repeat (count) gen_random_sample();
  endtask

  task automatic set_window(logic [WIDTH_W-1:0] lo, logic [WIDTH_W-1:0] hi);
    wait_drained();
    write_window_reg(REG_MIN_WIDTH, lo);
    write_window_reg(REG_MAX_WIDTH, hi);
    window_cnt++;
  endtask

  initial begin
    for (int i = 0; i < CH_SLOTS; i++) begin
      chan_high[i]  = 1'b0;
      chan_rise[i]  = '0;
      chan_width[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default window: rise at time zero, then the window edges
    push_sample(4'hF, 32'd0);
    push_sample(4'h0, 32'd1500);
    push_sample(4'hF, 32'd10000);
    push_sample(4'hD, 32'd10999);
    push_sample(4'hC, 32'd11000);
    push_sample(4'h8, 32'd12000);
    push_sample(4'h0, 32'd12001);
    // pulse across the timestamp wrap
    push_sample(4'hF, 32'hFFFF_FC00);
    push_sample(4'hF, 32'hFFFF_FFFF);
    push_sample(4'h0, 32'h0000_0200);
    // level held and repeated lows change nothing, then pairs of channels swap
    push_sample(4'h0, 32'h0000_0300);
    push_sample(4'h5, 32'h0000_0400);
    push_sample(4'hA, 32'h0000_0A00);
    push_sample(4'h0, 32'h0000_1000);
    run_random(300);

    // Widest window: zero width, largest width, one past it
    set_window(16'd0, 16'hFFFF);
    push_sample(4'h0, 32'd4000);
    push_sample(4'hF, 32'd5000);
    push_sample(4'hE, 32'd5000);
    push_sample(4'hC, 32'd5000 + 32'd65535);
    push_sample(4'h8, 32'd5000 + 32'd65536);
    push_sample(4'h0, 32'd5000 + 32'h8000_0000);
    push_sample(4'hF, 32'hFFFF_FFFF);
    push_sample(4'h0, 32'hFFFF_FFFF);
    run_random(250);

    // Inverted window: nothing is ever captured
    set_window(16'd3000, 16'd1000);
    run_random(150);

    // Single-value window
    set_window(16'd1500, 16'd1500);
    push_sample(4'h0, 32'd100);
    push_sample(4'hF, 32'd200);
    push_sample(4'h3, 32'd1700);
    push_sample(4'h0, 32'd1701);
    run_random(200);

    // Random window, no idling on either side
    set_window(16'($urandom_range(500, 1200)), 16'($urandom_range(1300, 2500)));
    quiet = 1'b1;
    run_random(350);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_widths_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_widths_q.size());
      err_cnt++;
    end
    $display("covered %0d pin samples and %0d results, %0d channel widths captured",
             sample_cnt, result_cnt, capture_cnt);
    $display("over %0d acceptance windows, %0d mismatches", window_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("[rc_pulse_width_capture_unit] OK");
    end else begin
      $display("[rc_pulse_width_capture_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rcpwc_pkg.sv
design/rcpwc_cfg_regs.sv
design/rcpwc_channel.sv
design/rc_pulse_width_capture_unit.sv
design/rcpwc_checker.sv
dv/tb_rc_pulse_width_capture_unit.sv
